@@ src/assert_macros.svh @@
// assertion macros shared by the row evolver rtl
// no dependencies; included by the modules that carry assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define LLRE_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define LLRE_ASSERT_NEVER(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define LLRE_ASSERT(label, clk, rst, prop, msg)
`define LLRE_ASSERT_NEVER(label, clk, rst, expr, msg)
`endif
`endif

@@ src/llre_pkg.sv @@
// shared constants and types of the life-like row evolver
// no dependencies; imported by the interfaces and every module
package llre_pkg;

   localparam int CELL_W        = 64;
   localparam int DEF_ROW_CELLS = 64;
   localparam int RULE_W        = 9;
   localparam int ALIVE_W       = 7;
   localparam int TOTAL_W       = 13;
   localparam int CSR_IDX_W     = 2;

   localparam logic [RULE_W-1:0] BIRTH_RESET   = RULE_W'(8);
   localparam logic [RULE_W-1:0] SURVIVE_RESET = RULE_W'(12);

   // register indexes of the csr port
   localparam logic [CSR_IDX_W-1:0] CSR_BIRTH   = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_SURVIVE = CSR_IDX_W'(1);

   typedef struct packed {
      logic first;
      logic last;
   } llre_tag_type;

endpackage

@@ src/llre_if.sv @@
// valid/ready channels of the row evolver: row input, result output, csr write
// depends on llre_pkg
interface llre_req_if;
   import llre_pkg::*;
   logic              valid;
   logic              ready;
   logic [CELL_W-1:0] row_cells;
   logic              left_halo;
   logic              right_halo;
   logic              chunk_start;
   modport source (output valid, row_cells, left_halo, right_halo, chunk_start, input ready);
   modport sink (input valid, row_cells, left_halo, right_halo, chunk_start, output ready);
endinterface

interface llre_rsp_if;
   import llre_pkg::*;
   logic               valid;
   logic               ready;
   logic [CELL_W-1:0]  next_row;
   logic [ALIVE_W-1:0] row_alive;
   logic [TOTAL_W-1:0] chunk_alive;
   logic               last_row;
   modport source (output valid, next_row, row_alive, chunk_alive, last_row, input ready);
   modport sink (input valid, next_row, row_alive, chunk_alive, last_row, output ready);
endinterface

interface llre_csr_if;
   import llre_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [RULE_W-1:0]    data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

@@ src/life_like_row_evolver_top.sv @@
// Life-like row evolver: one row of a chunk enters per cycle on req_bus, in the order top
// halo row (chunk_start set), ROW_CELLS rows, bottom halo row; each row after the second
// gives one result on rsp_bus, registered first in the evaluation register and then in
// the result register. Rate is one row per clock while rsp_bus keeps up, set by those two
// registers; req_bus.ready drops only while both hold rows that rsp_bus has not taken.
// Depends on llre_pkg, llre_if, llre_window, llre_evolve and llre_result.
module life_like_row_evolver_top #(
   parameter int ROW_CELLS = llre_pkg::DEF_ROW_CELLS
) (
   input  logic        clock,
   input  logic        reset,
   llre_req_if.sink    req_bus,
   llre_rsp_if.source  rsp_bus,
   llre_csr_if.sink    csr_bus
);
   import llre_pkg::*;

   localparam int CNT_W = $clog2(ROW_CELLS + 1);

   logic                 take;
   logic                 s1_valid;
   llre_tag_type         s1_tag;
   logic [ROW_CELLS+1:0] s1_up, s1_mid, s1_dn;
   logic [RULE_W-1:0]    birth_mask, survive_mask;
   logic [ROW_CELLS-1:0] next_row;
   logic [CNT_W-1:0]     row_count;

   llre_window #(.ROW_CELLS(ROW_CELLS)) u_window (
      .clock    (clock),
      .reset    (reset),
      .req_bus  (req_bus),
      .take     (take),
      .s1_valid (s1_valid),
      .s1_tag   (s1_tag),
      .s1_up    (s1_up),
      .s1_mid   (s1_mid),
      .s1_dn    (s1_dn)
   );

   llre_evolve #(.ROW_CELLS(ROW_CELLS)) u_evolve (
      .up_row       (s1_up),
      .mid_row      (s1_mid),
      .dn_row       (s1_dn),
      .birth_mask   (birth_mask),
      .survive_mask (survive_mask),
      .next_row     (next_row),
      .row_count    (row_count)
   );

   llre_result #(.ROW_CELLS(ROW_CELLS)) u_result (
      .clock        (clock),
      .reset        (reset),
      .csr_bus      (csr_bus),
      .rsp_bus      (rsp_bus),
      .s1_valid     (s1_valid),
      .s1_tag       (s1_tag),
      .next_row     (next_row),
      .row_count    (row_count),
      .take         (take),
      .birth_mask   (birth_mask),
      .survive_mask (survive_mask)
   );

endmodule

@@ src/llre_window.sv @@
// row intake: two-row window, chunk row counter and the evaluation register
// depends on llre_pkg, llre_if and assert_macros.svh
`include "assert_macros.svh"

module llre_window #(
   parameter int ROW_CELLS = llre_pkg::DEF_ROW_CELLS
) (
   input  logic                     clock,
   input  logic                     reset,
   llre_req_if.sink                 req_bus,
   input  logic                     take,
   output logic                     s1_valid,
   output llre_pkg::llre_tag_type   s1_tag,
   output logic [ROW_CELLS+1:0]     s1_up,
   output logic [ROW_CELLS+1:0]     s1_mid,
   output logic [ROW_CELLS+1:0]     s1_dn
);
   import llre_pkg::*;

   localparam int WIN_W = ROW_CELLS + 2;
   localparam int RS_W  = $clog2(ROW_CELLS + 3);
   localparam logic [RS_W-1:0] RS_ZERO = RS_W'(0);
   localparam logic [RS_W-1:0] RS_ONE  = RS_W'(1);
   localparam logic [RS_W-1:0] RS_TWO  = RS_W'(2);
   localparam logic [RS_W-1:0] RS_LAST = RS_W'(ROW_CELLS + 1);
   localparam logic [RS_W-1:0] RS_DONE = RS_W'(ROW_CELLS + 2);

   logic [WIN_W-1:0] upper_ff, upper_in;
   logic [WIN_W-1:0] middle_ff, middle_in;
   logic [RS_W-1:0]  rows_seen_ff, rows_seen_in;
   logic             s1_valid_ff, s1_valid_in;
   llre_tag_type     s1_tag_ff, s1_tag_in;
   logic [WIN_W-1:0] s1_up_ff, s1_mid_ff, s1_dn_ff;

   logic [WIN_W-1:0] row_in;
   logic             accept;
   logic             chunk_open;
   logic             produce;

   // halo bits sit at both ends so column i sees its left neighbour at bit i
   assign row_in = {req_bus.right_halo, req_bus.row_cells[ROW_CELLS-1:0], req_bus.left_halo};
   assign req_bus.ready = !s1_valid_ff || take;
   assign accept = req_bus.valid && req_bus.ready;
   assign chunk_open = (rows_seen_ff != RS_ZERO) && (rows_seen_ff < RS_DONE);
   assign produce = accept && !req_bus.chunk_start && (rows_seen_ff >= RS_TWO)
                    && (rows_seen_ff < RS_DONE);

   always_comb begin
      upper_in     = upper_ff;
      middle_in    = middle_ff;
      rows_seen_in = rows_seen_ff;
      if (accept && req_bus.chunk_start) begin
         upper_in     = '0;
         middle_in    = row_in;
         rows_seen_in = RS_ONE;
      end else if (accept && chunk_open) begin
         upper_in     = middle_ff;
         middle_in    = row_in;
         rows_seen_in = rows_seen_ff + RS_ONE;
      end
   end

   always_comb begin
      s1_valid_in     = produce || (s1_valid_ff && !take);
      s1_tag_in.first = (rows_seen_ff == RS_TWO);
      s1_tag_in.last  = (rows_seen_ff == RS_LAST);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upper_ff     <= '0;
         middle_ff    <= '0;
         rows_seen_ff <= RS_ZERO;
         s1_valid_ff  <= 1'b0;
      end else begin
         upper_ff     <= upper_in;
         middle_ff    <= middle_in;
         rows_seen_ff <= rows_seen_in;
         s1_valid_ff  <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (produce) begin
         s1_tag_ff <= s1_tag_in;
         s1_up_ff  <= upper_ff;
         s1_mid_ff <= middle_ff;
         s1_dn_ff  <= row_in;
      end
   end

   assign s1_valid = s1_valid_ff;
   assign s1_tag   = s1_tag_ff;
   assign s1_up    = s1_up_ff;
   assign s1_mid   = s1_mid_ff;
   assign s1_dn    = s1_dn_ff;

   `LLRE_ASSERT_NEVER(a_rows_bound, clock, reset, rows_seen_ff > RS_DONE, "row counter overran")
   `LLRE_ASSERT(a_start_loads, clock, reset, (accept && req_bus.chunk_start) |=> (rows_seen_ff == RS_ONE), "chunk start did not open a chunk")
   `LLRE_ASSERT(a_stall_holds, clock, reset, (s1_valid_ff && !take) |=> s1_valid_ff, "evaluated row dropped while stalled")
   `LLRE_ASSERT_NEVER(a_tag_excl, clock, reset, s1_valid_ff && s1_tag_ff.first && s1_tag_ff.last, "row tagged first and last")

endmodule

@@ src/llre_evolve.sv @@
// next-generation rule: bit-sliced neighbour count and birth/survive lookup
// depends on llre_pkg
module llre_evolve #(
   parameter int ROW_CELLS = llre_pkg::DEF_ROW_CELLS
) (
   input  logic [ROW_CELLS+1:0]                 up_row,
   input  logic [ROW_CELLS+1:0]                 mid_row,
   input  logic [ROW_CELLS+1:0]                 dn_row,
   input  logic [llre_pkg::RULE_W-1:0]          birth_mask,
   input  logic [llre_pkg::RULE_W-1:0]          survive_mask,
   output logic [ROW_CELLS-1:0]                 next_row,
   output logic [$clog2(ROW_CELLS+1)-1:0]       row_count
);
   import llre_pkg::*;

   localparam int CNT_W = $clog2(ROW_CELLS + 1);

   logic [ROW_CELLS-1:0] plane [8];
   logic [ROW_CELLS-1:0] sum_bit [4];
   logic [15:0]          birth_wide;
   logic [15:0]          survive_wide;

   // eight neighbour planes, each already shifted onto the target column
   assign plane[0] = up_row[ROW_CELLS-1:0];
   assign plane[1] = up_row[ROW_CELLS:1];
   assign plane[2] = up_row[ROW_CELLS+1:2];
   assign plane[3] = mid_row[ROW_CELLS-1:0];
   assign plane[4] = mid_row[ROW_CELLS+1:2];
   assign plane[5] = dn_row[ROW_CELLS-1:0];
   assign plane[6] = dn_row[ROW_CELLS:1];
   assign plane[7] = dn_row[ROW_CELLS+1:2];

   // counts never exceed eight, upper codes read as zero
   assign birth_wide   = 16'(birth_mask);
   assign survive_wide = 16'(survive_mask);

   // ripple each plane into a 4-bit per-column counter
   always_comb begin
      logic [ROW_CELLS-1:0] k0, k1, k2;
      for (int b = 0; b < 4; b++) begin
         sum_bit[b] = '0;
      end
      for (int p = 0; p < 8; p++) begin
         k0 = sum_bit[0] & plane[p];
         sum_bit[0] = sum_bit[0] ^ plane[p];
         k1 = sum_bit[1] & k0;
         sum_bit[1] = sum_bit[1] ^ k0;
         k2 = sum_bit[2] & k1;
         sum_bit[2] = sum_bit[2] ^ k1;
         sum_bit[3] = sum_bit[3] ^ k2;
      end
   end

   always_comb begin
      logic [3:0] cnt;
      for (int i = 0; i < ROW_CELLS; i++) begin
         cnt = {sum_bit[3][i], sum_bit[2][i], sum_bit[1][i], sum_bit[0][i]};
         next_row[i] = mid_row[i+1] ? survive_wide[cnt] : birth_wide[cnt];
      end
   end

   // pairwise adder tree, log-depth over the padded row
   always_comb begin
      logic [CELL_W-1:0]  padded;
      logic [ALIVE_W-1:0] part [CELL_W];
      padded = CELL_W'(next_row);
      for (int i = 0; i < CELL_W; i++) begin
         part[i] = ALIVE_W'(padded[i]);
      end
      for (int step = 1; step < CELL_W; step = step * 2) begin
         for (int i = 0; i < CELL_W; i = i + 2 * step) begin
            part[i] = part[i] + part[i+step];
         end
      end
      row_count = CNT_W'(part[0]);
   end

endmodule

@@ src/llre_result.sv @@
// rule registers, chunk live total and the result register
// depends on llre_pkg, llre_if and assert_macros.svh
`include "assert_macros.svh"

module llre_result #(
   parameter int ROW_CELLS = llre_pkg::DEF_ROW_CELLS
) (
   input  logic                               clock,
   input  logic                               reset,
   llre_csr_if.sink                           csr_bus,
   llre_rsp_if.source                         rsp_bus,
   input  logic                               s1_valid,
   input  llre_pkg::llre_tag_type             s1_tag,
   input  logic [ROW_CELLS-1:0]               next_row,
   input  logic [$clog2(ROW_CELLS+1)-1:0]     row_count,
   output logic                               take,
   output logic [llre_pkg::RULE_W-1:0]        birth_mask,
   output logic [llre_pkg::RULE_W-1:0]        survive_mask
);
   import llre_pkg::*;

   localparam int CNT_W = $clog2(ROW_CELLS + 1);

   logic [RULE_W-1:0]    birth_ff, birth_in;
   logic [RULE_W-1:0]    survive_ff, survive_in;
   logic                 out_valid_ff, out_valid_in;
   logic [ROW_CELLS-1:0] next_row_ff;
   logic [CNT_W-1:0]     row_alive_ff;
   logic                 last_row_ff;
   logic [TOTAL_W-1:0]   chunk_alive_ff, chunk_alive_in;
   logic                 load;

   assign csr_bus.ready = 1'b1;

   always_comb begin
      birth_in   = birth_ff;
      survive_in = survive_ff;
      if (csr_bus.valid) begin
         case (csr_bus.index)
            CSR_BIRTH:   birth_in = csr_bus.data;
            CSR_SURVIVE: survive_in = csr_bus.data;
            default: ;
         endcase
      end
   end

   assign take = !out_valid_ff || rsp_bus.ready;
   assign load = s1_valid && take;

   always_comb begin
      out_valid_in   = load || (out_valid_ff && !rsp_bus.ready);
      chunk_alive_in = chunk_alive_ff;
      // the first result of a chunk restarts the total
      if (load) begin
         if (s1_tag.first) begin
            chunk_alive_in = TOTAL_W'(row_count);
         end else begin
            chunk_alive_in = chunk_alive_ff + TOTAL_W'(row_count);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         birth_ff       <= BIRTH_RESET;
         survive_ff     <= SURVIVE_RESET;
         out_valid_ff   <= 1'b0;
         chunk_alive_ff <= '0;
      end else begin
         birth_ff       <= birth_in;
         survive_ff     <= survive_in;
         out_valid_ff   <= out_valid_in;
         chunk_alive_ff <= chunk_alive_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         next_row_ff  <= next_row;
         row_alive_ff <= row_count;
         last_row_ff  <= s1_tag.last;
      end
   end

   assign birth_mask          = birth_ff;
   assign survive_mask        = survive_ff;
   assign rsp_bus.valid       = out_valid_ff;
   assign rsp_bus.next_row    = CELL_W'(next_row_ff);
   assign rsp_bus.row_alive   = ALIVE_W'(row_alive_ff);
   assign rsp_bus.chunk_alive = chunk_alive_ff;
   assign rsp_bus.last_row    = last_row_ff;

   `LLRE_ASSERT_NEVER(a_alive_bound, clock, reset, out_valid_ff && (row_alive_ff > CNT_W'(ROW_CELLS)), "row count above row width")
   `LLRE_ASSERT(a_first_total, clock, reset, (load && s1_tag.first) |=> (chunk_alive_ff == TOTAL_W'(row_alive_ff)), "chunk total not restarted")
   `LLRE_ASSERT(a_total_grows, clock, reset, (load && !s1_tag.first) |=> (chunk_alive_ff == TOTAL_W'($past(chunk_alive_ff) + TOTAL_W'(row_alive_ff))), "chunk total not accumulated")

endmodule

@@ test/life_like_row_evolver_top_tb.sv @@
// self-checking testbench of life_like_row_evolver_top: streams chunks of rows with random
// gaps on both sides, predicts every next-generation row and compares each result in order
// depends on llre_pkg, llre_if and the row evolver rtl
module life_like_row_evolver_top_tb;
   import llre_pkg::*;

   localparam int ROWS        = DEF_ROW_CELLS;
   localparam int HALF_PERIOD = 6;
   localparam int DRAIN       = 6;
   localparam int STALL_LIMIT = 2000;
   localparam int HOLD_CYCLES = 300;
   localparam int MAX_REPORTS = 10;

   typedef struct packed {
      logic [CELL_W-1:0] cells;
      logic              left_halo;
      logic              right_halo;
      logic              chunk_start;
   } row_item_type;

   typedef struct packed {
      logic [CELL_W-1:0]  next_row;
      logic [ALIVE_W-1:0] row_alive;
      logic [TOTAL_W-1:0] chunk_alive;
      logic               last_row;
   } gen_result_type;

   logic clock = 1'b0;
   logic reset;

   llre_req_if req_bus ();
   llre_rsp_if rsp_bus ();
   llre_csr_if csr_bus ();

   life_like_row_evolver_top #(.ROW_CELLS(ROWS)) u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   // predicted block state
   logic [RULE_W-1:0]  birth_rule    = BIRTH_RESET;
   logic [RULE_W-1:0]  survive_rule  = SURVIVE_RESET;
   logic [CELL_W+1:0]  win_above     = '0;
   logic [CELL_W+1:0]  win_middle    = '0;
   int unsigned        rows_in_chunk = 0;
   logic [TOTAL_W-1:0] live_total    = '0;
   gen_result_type     pending_rows[$];

   int rows_offered = 0;
   int rows_ignored = 0;
   int results_seen = 0;
   int chunks_done  = 0;
   int rule_sets    = 1;
   int errors       = 0;
   int req_gap_pct  = 33;
   int rsp_gap_pct  = 33;
   bit hold_req     = 1'b0;

   always begin
      #HALF_PERIOD clock = 1'b1;
      #HALF_PERIOD clock = 1'b0;
   end

   // bit 0 is the left halo, bit ROWS+1 the right halo
   function automatic logic [CELL_W+1:0] extend_row(input row_item_type item);
      logic [CELL_W+1:0] ext;
      ext = '0;
      ext[0] = item.left_halo;
      ext[ROWS:1] = item.cells[ROWS-1:0];
      ext[ROWS+1] = item.right_halo;
      return ext;
   endfunction

   function automatic logic [CELL_W-1:0] next_generation(input logic [CELL_W+1:0] above,
                                                          input logic [CELL_W+1:0] mid,
                                                          input logic [CELL_W+1:0] below);
      logic [CELL_W-1:0] nxt;
      int unsigned       nb;
      nxt = '0;
      for (int i = 0; i < ROWS; i++) begin
         nb = mid[i] + mid[i+2];
         for (int d = 0; d < 3; d++) nb += above[i+d] + below[i+d];
         nxt[i] = mid[i+1] ? survive_rule[nb] : birth_rule[nb];
      end
      return nxt;
   endfunction

   function automatic void advance_window(input row_item_type item);
      logic [CELL_W+1:0] ext;
      gen_result_type    res;
      ext = extend_row(item);
      if (item.chunk_start) begin
         win_above     = '0;
         win_middle    = ext;
         rows_in_chunk = 1;
         live_total    = '0;
      end else if (rows_in_chunk == 0 || rows_in_chunk >= ROWS + 2) begin
         rows_ignored++;
      end else begin
         if (rows_in_chunk >= 2) begin
            res.next_row    = next_generation(win_above, win_middle, ext);
            res.row_alive   = ALIVE_W'($countones(res.next_row));
            live_total      += TOTAL_W'(res.row_alive);
            res.chunk_alive = live_total;
            res.last_row    = (rows_in_chunk == ROWS + 1);
            pending_rows.push_back(res);
         end
         win_above  = win_middle;
         win_middle = ext;
         rows_in_chunk++;
      end
   endfunction

   function automatic row_item_type make_row(input bit start);
      row_item_type      item;
      logic [CELL_W-1:0] a;
      logic [CELL_W-1:0] b;
      a = {$urandom, $urandom};
      b = {$urandom, $urandom};
      case ($urandom_range(7))
         0, 1: item.cells = a & b & {$urandom, $urandom};
         2: item.cells = a | b;
         3: item.cells = '0;
         4: item.cells = '1;
         default: item.cells = a;
      endcase
      item.left_halo   = 1'($urandom_range(1));
      item.right_halo  = 1'($urandom_range(1));
      item.chunk_start = start;
      return item;
   endfunction

   task automatic offer_row(input row_item_type item);
      @(negedge clock);
      while ($urandom_range(99) < req_gap_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.row_cells   <= item.cells;
      req_bus.left_halo   <= item.left_halo;
      req_bus.right_halo  <= item.right_halo;
      req_bus.chunk_start <= item.chunk_start;
      do @(posedge clock); while (!req_bus.ready);
      advance_window(item);
      rows_offered++;
   endtask

   task automatic release_rows();
      @(negedge clock);
      req_bus.valid <= 1'b0;
   endtask

   // rule registers change only with the pipeline drained
   task automatic write_rule(input logic [CSR_IDX_W-1:0] idx, input logic [RULE_W-1:0] value);
      while (pending_rows.size() != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);
      @(negedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= value;
      do @(posedge clock); while (!csr_bus.ready);
      case (idx)
         CSR_BIRTH: birth_rule = value;
         CSR_SURVIVE: survive_rule = value;
         default: ;
      endcase
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   task automatic set_rules(input logic [RULE_W-1:0] births, input logic [RULE_W-1:0] survives);
      write_rule(CSR_BIRTH, births);
      write_rule(CSR_SURVIVE, survives);
      rule_sets++;
   endtask

   // top halo, ROWS rows, bottom halo; break_at > 0 abandons the chunk at that row
   task automatic send_chunk(input int break_at, input int trailing);
      offer_row(make_row(1'b1));
      for (int r = 1; r <= ROWS + 1; r++) begin
         if (r == break_at) return;
         offer_row(make_row(1'b0));
      end
      repeat (trailing) offer_row(make_row(1'b0));
   endtask

   task automatic random_chunk();
      int break_at;
      break_at = ($urandom_range(7) == 0) ? int'($urandom_range(ROWS, 1)) : 0;
      send_chunk(break_at, int'($urandom_range(2)));
   endtask

   task automatic test_orphan_rows();
      offer_row(row_item_type'{'1, 1'b1, 1'b1, 1'b0});
      offer_row(row_item_type'{'0, 1'b0, 1'b0, 1'b0});
      offer_row(make_row(1'b0));
      release_rows();
   endtask

   task automatic test_abandoned_chunk();
      offer_row(row_item_type'{'1, 1'b1, 1'b1, 1'b1});
      // restart before any body row arrives
      offer_row(row_item_type'{'0, 1'b0, 1'b0, 1'b1});
      repeat (3) offer_row(row_item_type'{'1, 1'b1, 1'b1, 1'b0});
      offer_row(row_item_type'{'0, 1'b0, 1'b0, 1'b0});
      offer_row(row_item_type'{{32{2'b10}}, 1'b1, 1'b0, 1'b0});
      offer_row(row_item_type'{{32{2'b01}}, 1'b0, 1'b1, 1'b0});
      offer_row(make_row(1'b1));
      repeat (3) offer_row(make_row(1'b0));
      offer_row(make_row(1'b1));
      release_rows();
   endtask

   task automatic test_trailing_rows();
      send_chunk(0, 3);
      release_rows();
   endtask

   task automatic test_rule_sweep();
      logic [RULE_W-1:0] births   [5];
      logic [RULE_W-1:0] survives [5];
      births   = '{'0, '1, '1, '0, BIRTH_RESET};
      survives = '{'0, '1, '0, '1, SURVIVE_RESET};
      for (int k = 0; k < 6; k++) begin
         if (k < 5) begin
            set_rules(births[k], survives[k]);
         end else begin
            set_rules(RULE_W'($urandom_range(511)), RULE_W'($urandom_range(511)));
         end
         random_chunk();
         release_rows();
      end
   endtask

   task automatic test_no_idle();
      req_gap_pct = 0;
      rsp_gap_pct = 0;
      send_chunk(0, 1);
      release_rows();
      req_gap_pct = 33;
      rsp_gap_pct = 33;
   endtask

   task automatic test_backpressure();
      @(posedge clock);
      hold_req    = 1'b1;
      req_gap_pct = 0;
      send_chunk(0, 0);
      release_rows();
      req_gap_pct = 33;
   endtask

   initial begin : rsp_throttle
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_req) begin
            hold_req = 1'b0;
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         rsp_bus.ready <= ($urandom_range(99) >= rsp_gap_pct);
      end
   end

   always @(posedge clock) begin : result_check
      gen_result_type got;
      gen_result_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got = '{rsp_bus.next_row, rsp_bus.row_alive, rsp_bus.chunk_alive, rsp_bus.last_row};
         results_seen++;
         if (got.last_row === 1'b1) chunks_done++;
         if (pending_rows.size() == 0) begin
            errors++;
            if (errors <= MAX_REPORTS)
               $display("unexpected result transaction: next_row %h row_alive %0d chunk_alive %0d",
                        got.next_row, got.row_alive, got.chunk_alive);
         end else begin
            want = pending_rows.pop_front();
            if (got.next_row !== want.next_row || got.row_alive !== want.row_alive ||
                got.chunk_alive !== want.chunk_alive || got.last_row !== want.last_row) begin
               errors++;
               if (errors <= MAX_REPORTS) begin
                  $display("result %0d expected: next_row %h row_alive %0d chunk_alive %0d last %b",
                           results_seen, want.next_row, want.row_alive, want.chunk_alive,
                           want.last_row);
                  $display("result %0d actual:   next_row %h row_alive %0d chunk_alive %0d last %b",
                           results_seen, got.next_row, got.row_alive, got.chunk_alive,
                           got.last_row);
               end
            end
         end
      end
   end

   // ends the run when no transaction moves for too long
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
             (csr_bus.valid && csr_bus.ready)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("life_like_row_evolver_top regression: fail");
      $finish;
   end

   initial begin
      reset               = 1'b1;
      req_bus.valid       = 1'b0;
      req_bus.row_cells   = '0;
      req_bus.left_halo   = 1'b0;
      req_bus.right_halo  = 1'b0;
      req_bus.chunk_start = 1'b0;
      csr_bus.valid       = 1'b0;
      csr_bus.index       = CSR_BIRTH;
      csr_bus.data        = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_orphan_rows();
      test_abandoned_chunk();
      test_trailing_rows();
      test_rule_sweep();
      test_no_idle();
      test_backpressure();

      while (pending_rows.size() != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);
      $display("%0d rows sent (%0d dropped outside a chunk), %0d results checked, %0d chunks closed",
               rows_offered, rows_ignored, results_seen, chunks_done);
      $display("%0d birth/survive rule settings used, %0d mismatches", rule_sets, errors);
      if (errors == 0 && pending_rows.size() == 0) begin
         $display("life_like_row_evolver_top regression: pass");
      end else begin
         $display("life_like_row_evolver_top regression: fail");
      end
      $finish;
   end

endmodule

@@ files.f @@
+incdir+src
src/llre_pkg.sv
src/llre_if.sv
src/llre_window.sv
src/llre_evolve.sv
src/llre_result.sv
src/life_like_row_evolver_top.sv
test/life_like_row_evolver_top_tb.sv
